[src/bfa_pkg.sv]
package bfa_pkg;

	localparam int unsigned NUM_BITS_DEF  = 4096;
	localparam int unsigned WORD_BITS_DEF = 32;

	localparam int unsigned CAP_W     = 13;
	localparam int unsigned IDX_W     = 12;
	localparam int unsigned STS_W     = 2;
	localparam int unsigned CAP_RESET = 4096;

	localparam logic [STS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STS_W-1:0] ST_RANGE = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic clr;        // clearing pass: zero one word
		logic load;       // latch item, start scan at word 0
		logic scan;       // check current word, advance if none free
		logic fdiv;       // compute word index of free index
		logic frd;        // read word to be freed, compute bit offset
		logic fwr;        // write back with bit cleared
		logic res_full;
		logic res_range;
		logic push;       // move result into output register
	} bfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic cap_zero;
		logic found;
		logic more;
		logic in_range;
	} bfa_stat_t;

endpackage

[src/bfa_ram.sv]
module bfa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/bfa_dpath.sv]
module bfa_dpath import bfa_pkg::*; #(
	parameter int unsigned NUM_BITS  = NUM_BITS_DEF,
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bfa_cmd_t         cmd,
	output bfa_stat_t        stat,
	input  logic [IDX_W-1:0] idx_in,
	input  logic [CAP_W-1:0] cap,
	output logic [IDX_W-1:0] out_index,
	output logic [STS_W-1:0] out_status
);

	localparam int unsigned WORD_COUNT = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int unsigned BW     = $clog2(WORD_BITS);
	localparam int unsigned NB_W   = $clog2(NUM_BITS + WORD_BITS + 1);
	localparam int unsigned EW     = (NB_W > CAP_W) ? NB_W : CAP_W;
	// index / WORD_BITS as multiply by rounded-up reciprocal, exact for IDX_W-bit input
	localparam int unsigned DIV_SH = IDX_W + $clog2(WORD_BITS);
	localparam int unsigned DIV_M  = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned MW     = $clog2(DIV_M + 1);
	localparam int unsigned PW     = IDX_W + MW;

	logic [IDX_W-1:0]     idx_q;
	logic [EW-1:0]        base_q;
	logic [AW-1:0]        word_q;
	logic [AW-1:0]        q_q;
	logic [BW-1:0]        bit_q;
	logic [AW-1:0]        clr_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic [STS_W-1:0]     res_sts_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [STS_W-1:0]     out_sts_q;

	logic [EW-1:0]        eff;
	logic [EW-1:0]        rem;
	logic [EW-1:0]        base_nxt;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free_vec;
	logic [BW-1:0]        pos;
	logic                 found;
	logic                 more;
	logic [PW-1:0]        prod;
	logic [IDX_W-1:0]     qwb;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rdata;

	// capacity saturates at the store size
	assign eff      = (EW'(cap) > EW'(NUM_BITS)) ? EW'(NUM_BITS) : EW'(cap);
	assign rem      = eff - base_q;
	assign base_nxt = base_q + EW'(WORD_BITS);
	assign more     = base_nxt < eff;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = EW'(b) < rem;
		end
	end

	assign free_vec = ~rdata & mask;
	assign found    = |free_vec;

	// lowest free bit
	always_comb begin
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				pos = BW'(b);
			end
		end
	end

	assign prod = PW'(idx_q) * PW'(DIV_M);
	assign qwb  = IDX_W'(IDX_W'(q_q) * IDX_W'(WORD_BITS));

	always_comb begin
		priority if (cmd.load) begin
			raddr = '0;
		end else if (cmd.scan) begin
			raddr = more ? word_q + AW'(1) : word_q;
		end else begin
			raddr = q_q;
		end
	end

	always_comb begin
		we    = cmd.clr | (cmd.scan & found) | cmd.fwr;
		priority if (cmd.clr) begin
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.fwr) begin
			waddr = q_q;
			wdata = rdata & ~(WORD_BITS'(1) << bit_q);
		end else begin
			waddr = word_q;
			wdata = rdata | (WORD_BITS'(1) << pos);
		end
	end

	bfa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= idx_in;
			base_q <= '0;
			word_q <= '0;
		end else if (cmd.scan && !found) begin
			base_q <= base_nxt;
			word_q <= word_q + AW'(1);
		end
		if (cmd.fdiv) begin
			q_q <= AW'(prod >> DIV_SH);
		end
		if (cmd.frd) begin
			bit_q <= BW'(idx_q - qwb);
		end
		priority if (cmd.scan && found) begin
			res_idx_q <= IDX_W'(base_q + EW'(pos));
			res_sts_q <= ST_OK;
		end else if (cmd.fwr) begin
			res_idx_q <= '0;
			res_sts_q <= ST_OK;
		end else if (cmd.res_full) begin
			res_idx_q <= '0;
			res_sts_q <= ST_FULL;
		end else if (cmd.res_range) begin
			res_idx_q <= '0;
			res_sts_q <= ST_RANGE;
		end
		if (cmd.push) begin
			out_idx_q <= res_idx_q;
			out_sts_q <= res_sts_q;
		end
	end

	assign stat.clr_last = clr_q == AW'(WORD_COUNT - 1);
	assign stat.cap_zero = eff == '0;
	assign stat.found    = found;
	assign stat.more     = more;
	assign stat.in_range = EW'(idx_q) < eff;

	assign out_index  = out_idx_q;
	assign out_status = out_sts_q;

endmodule

[src/bfa_ctrl.sv]
module bfa_ctrl import bfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_op,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  bfa_stat_t stat,
	output bfa_cmd_t  cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ACHK  = 3'd2;
	localparam logic [2:0] S_FDIV  = 3'd3;
	localparam logic [2:0] S_FRD   = 3'd4;
	localparam logic [2:0] S_FWR   = 3'd5;
	localparam logic [2:0] S_PUSH  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_op == OP_FREE) begin
						state_nxt = S_FDIV;
					end else if (stat.cap_zero) begin
						cmd.res_full = 1'b1;
						state_nxt    = S_PUSH;
					end else begin
						state_nxt = S_ACHK;
					end
				end
			end
			S_ACHK: begin
				cmd.scan = 1'b1;
				if (stat.found) begin
					state_nxt = S_PUSH;
				end else if (!stat.more) begin
					cmd.res_full = 1'b1;
					state_nxt    = S_PUSH;
				end
			end
			S_FDIV: begin
				cmd.fdiv = 1'b1;
				if (stat.in_range) begin
					state_nxt = S_FRD;
				end else begin
					cmd.res_range = 1'b1;
					state_nxt     = S_PUSH;
				end
			end
			S_FRD: begin
				cmd.frd   = 1'b1;
				state_nxt = S_FWR;
			end
			S_FWR: begin
				cmd.fwr   = 1'b1;
				state_nxt = S_PUSH;
			end
			S_PUSH: begin
				if (!out_valid_q || out_ready) begin
					cmd.push  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

[src/bitmap_first_free_allocator.sv]
// Bitmap first-fit allocator.
// Input stream (s_*): one item is an allocate or a free request. s_tuser[0] is
// the operation (0 allocate, 1 free), s_tdata[11:0] the entry to free.
// Output stream (m_*): one item per request. m_tdata[11:0] is the allocated
// entry (zero unless an allocate succeeded), m_tuser[1:0] the status
// (0 ok, 1 no free entry, 2 index out of range).
// APB port: one register at byte address 0, the capacity (13 bits, reset 4096,
// saturated at NUM_BITS). Write it only while no request is in flight.
// Timing: an allocate reads one bitmap word per cycle through the RAM's single
// read port and scans at most NUM_BITS/WORD_BITS words (128 at the defaults).
// One request is in flight at a time; the next one is accepted as soon as the
// result sits in the output register.
// Reset: a clearing pass zeroes the bitmap RAM word by word; s_tready stays low
// until it is done. APB writes are taken during the pass.
// Stall: a result held by a low m_tready stays in the output register; one more
// request can be accepted and worked, then the block waits to deliver it.
module bitmap_first_free_allocator import bfa_pkg::*; #(
	parameter int unsigned NUM_BITS  = NUM_BITS_DEF,
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] bit_index, rest zero
	input  logic [0:0]  s_tuser,   // [0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] alloc_index, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CAP_W-1:0] cap_q;
	logic             cap_sel;
	bfa_cmd_t         cmd;
	bfa_stat_t        stat;
	logic [IDX_W-1:0] out_index;
	logic [STS_W-1:0] out_status;

	// register index 0 lives at byte address 0
	assign cap_sel = paddr[2] == 1'b0;
	assign pready  = 1'b1;
	assign prdata  = cap_sel ? 32'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser[0]),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfa_dpath #(
		.NUM_BITS (NUM_BITS),
		.WORD_BITS(WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.idx_in    (s_tdata[IDX_W-1:0]),
		.cap       (cap_q),
		.out_index (out_index),
		.out_status(out_status)
	);

	assign m_tdata = {4'b0, out_index};
	assign m_tuser = out_status;

	// one request at a time: an accept leaves the idle state
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is being worked");

	// only ok, full and out-of-range are produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_RANGE))
		else $error("undefined status code on result");

	// index is zero on full and out-of-range results
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[IDX_W-1:0] == '0)
		else $error("nonzero index on failed request");

	// a result is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!m_tvalid || m_tready))
		else $error("result overwritten before delivery");

endmodule
